// ===== sv/sca_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the sound channel priority allocator.
package sca_pkg;

  localparam int NUM_CHANNELS        = 8;
  localparam int MUSIC_CHANNEL_INDEX = 0;
  localparam int CODE_BITS           = 16;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);
  localparam logic [2:0] MUSIC_CH = 3'(MUSIC_CHANNEL_INDEX);
  localparam logic [15:0] CODE_MASK = 16'((32'd1 << CODE_BITS) - 32'd1);

  // Operation carried by the mode field of a transaction.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // Write request from the sequencer into the channel table.
  typedef struct packed {
    logic            en;
    logic [CH_W-1:0] idx;
    logic [7:0]      timer;
    logic [7:0]      prio;
  } sca_wr_t;

  // Flags and values produced by the shared compare/decrement unit.
  typedef struct packed {
    logic       busy;
    logic       expire;
    logic       eligible;
    logic [7:0] timer_dec;
  } sca_alu_t;

endpackage

// ===== sv/sca_table.sv =====
`timescale 1ns / 1ps
// Per-channel table of remaining-time counters and holding priorities.
module sca_table import sca_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  sca_wr_t         wr,
  input  logic [CH_W-1:0] rd_idx,
  output logic [7:0]      rd_timer,
  output logic [7:0]      rd_prio
);

  logic [7:0] timer [NUM_CHANNELS];
  logic [7:0] prio  [NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        timer[i] <= 8'd0;
        prio[i]  <= 8'd0;
      end
    end else if (wr.en) begin
      timer[wr.idx] <= wr.timer;
      prio[wr.idx]  <= wr.prio;
    end
  end

  assign rd_timer = timer[rd_idx];
  assign rd_prio  = prio[rd_idx];

endmodule

// ===== sv/sca_alu.sv =====
`timescale 1ns / 1ps
// Shared compare and decrement unit applied to one channel entry per cycle.
module sca_alu import sca_pkg::*; (
  input  logic [7:0] timer,
  input  logic [7:0] prio,
  input  logic [7:0] req_prio,
  output sca_alu_t   res
);

  always_comb begin
    res.busy      = (timer != 8'd0);
    res.timer_dec = timer - 8'd1;
    res.expire    = (timer == 8'd1);
    // A channel may be taken when idle or held at a priority not above the request.
    res.eligible  = !res.busy || (req_prio >= prio);
  end

endmodule

// ===== sv/sound_channel_priority_allocator.sv =====
`timescale 1ns / 1ps
// Sound channel priority allocator: a sequencer that scans the channel table.
//
// One transaction is taken at a time. After acceptance the sequencer visits
// the channels one per cycle through a single compare/decrement unit: a tick
// visits all NUM_CHANNELS channels, a start request stops at the first
// channel it is granted. The result is then held in an output register until
// it is taken, and only then is the next transaction accepted. No clearing
// pass is needed after reset.
module sound_channel_priority_allocator import sca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  channel_mask,
  input  logic [15:0] sound_code,
  input  logic [7:0]  duration,
  input  logic [7:0]  priority_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_valid,
  output logic [15:0] code_out,
  output logic [2:0]  granted_channel,
  output logic        music_stop,
  output logic        music_resume
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t          state;
  logic [CH_W-1:0] ch;
  logic            held;

  logic            mode_r;
  logic [7:0]      mask_r;
  logic [15:0]     code_r;
  logic [7:0]      dur_r;
  logic [7:0]      prio_r;

  logic [7:0]      rd_timer;
  logic [7:0]      rd_prio;
  sca_alu_t        alu;
  sca_wr_t         wr;

  logic            is_music;
  logic            grant;
  logic            scan_done;
  logic            music_expire;

  sca_table u_table (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_idx   (ch),
    .rd_timer (rd_timer),
    .rd_prio  (rd_prio)
  );

  sca_alu u_alu (
    .timer    (rd_timer),
    .prio     (rd_prio),
    .req_prio (prio_r),
    .res      (alu)
  );

  always_comb begin
    is_music     = (3'(ch) == MUSIC_CH);
    grant        = (state == ST_SCAN) && (mode_r == MODE_START) && mask_r[ch] &&
                   alu.eligible;
    scan_done    = grant || (ch == LAST_CH);
    music_expire = (state == ST_SCAN) && (mode_r == MODE_TICK) && alu.expire && is_music;

    wr       = '0;
    wr.idx   = ch;
    wr.timer = rd_timer;
    wr.prio  = rd_prio;
    if (state == ST_SCAN) begin
      if (mode_r == MODE_TICK) begin
        if (alu.busy) begin
          wr.en    = 1'b1;
          wr.timer = alu.timer_dec;
          if (alu.expire) begin
            wr.prio = 8'd0;
          end
        end
      end else if (grant && (dur_r != 8'd0)) begin
        wr.en    = 1'b1;
        wr.timer = dur_r;
        wr.prio  = prio_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      held  <= 1'b0;
      ch    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            mode_r          <= mode;
            mask_r          <= channel_mask;
            code_r          <= sound_code;
            dur_r           <= duration;
            prio_r          <= priority_req;
            ch              <= '0;
            write_valid     <= 1'b0;
            code_out        <= 16'd0;
            granted_channel <= 3'd0;
            music_stop      <= 1'b0;
            music_resume    <= 1'b0;
            state           <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (music_expire) begin
            music_resume <= 1'b1;
            held         <= 1'b0;
          end
          if (grant) begin
            write_valid     <= 1'b1;
            code_out        <= code_r & CODE_MASK;
            granted_channel <= 3'(ch);
            if ((dur_r != 8'd0) && is_music) begin
              music_stop <= 1'b1;
              held       <= 1'b1;
            end
          end
          if (scan_done) begin
            state <= ST_OUT;
          end else begin
            ch <= ch + 1'b1;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

  // A timed grant of the music channel leaves the music marked as held.
  a_stop_sets_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && music_stop |-> held)
    else $error("music stopped but not marked held");

  // A stop only comes with a grant, and never together with a resume.
  a_stop_needs_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && music_stop |-> write_valid && !music_resume)
    else $error("music stop without grant or with resume");

  // Ticks never grant a channel.
  a_tick_no_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mode_r == MODE_TICK) |-> !write_valid)
    else $error("tick produced a grant");

  // The scan counter never runs past the last channel.
  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> ch <= LAST_CH)
    else $error("channel counter out of range");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sound channel priority allocator.
module tb_top;
  import sca_pkg::*;

  localparam int DIR_ROWS     = 24;
  localparam int RAND_ITEMS   = 1730;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 600;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PRINT_CAP    = 200;

  localparam logic [15:0] CODE_KEEP = 16'hFFFF >> (16 - CODE_BITS);

  typedef struct packed {
    logic       mode;
    logic [7:0] mask;
    logic [15:0] code;
    logic [7:0] dur;
    logic [7:0] prio;
  } alloc_req_t;

  typedef struct packed {
    logic        wv;
    logic [15:0] code;
    logic [2:0]  ch;
    logic        stop;
    logic        resume;
  } alloc_res_t;

  typedef struct packed {
    logic       typed;
    alloc_req_t req;
    alloc_res_t res;
  } dir_row_t;

  localparam alloc_res_t NO_GRANT = '0;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [7:0]  channel_mask;
  logic [15:0] sound_code;
  logic [7:0]  duration;
  logic [7:0]  priority_req;
  logic        out_valid;
  logic        out_stall;
  logic        write_valid;
  logic [15:0] code_out;
  logic [2:0]  granted_channel;
  logic        music_stop;
  logic        music_resume;

  // Shadow copy of the channel table.
  logic [7:0] ch_timer [8];
  logic [7:0] ch_prio  [8];
  logic       music_held;

  alloc_res_t predicted_allocs [$];
  alloc_res_t want;

  int err_count    = 0;
  int results_seen = 0;
  int cycle_count  = 0;
  int n_ticks      = 0;
  int n_grants     = 0;
  int n_refused    = 0;
  int n_stops      = 0;
  int n_resumes    = 0;
  bit long_hold_done = 1'b0;

  sound_channel_priority_allocator u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .channel_mask    (channel_mask),
    .sound_code      (sound_code),
    .duration        (duration),
    .priority_req    (priority_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .write_valid     (write_valid),
    .code_out        (code_out),
    .granted_channel (granted_channel),
    .music_stop      (music_stop),
    .music_resume    (music_resume)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Rows with the typed flag set carry an expectation that follows directly
  // from the channel table; the others are left to the predictor.
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{1'b1, '{MODE_START, 8'h00, 16'hABCD, 8'd5,   8'd9},   NO_GRANT},
    '{1'b1, '{MODE_TICK,  8'hFF, 16'hFFFF, 8'hFF,  8'hFF},  NO_GRANT},
    '{1'b1, '{MODE_START, 8'hFF, 16'hFFFF, 8'd0,   8'd0},   '{1'b1, 16'hFFFF, 3'd0, 1'b0, 1'b0}},
    '{1'b1, '{MODE_START, 8'h01, 16'h1234, 8'd3,   8'd5},   '{1'b1, 16'h1234, 3'd0, 1'b1, 1'b0}},
    '{1'b1, '{MODE_START, 8'h01, 16'h5555, 8'd1,   8'd4},   NO_GRANT},
    '{1'b1, '{MODE_START, 8'h01, 16'h0000, 8'd3,   8'd5},   '{1'b1, 16'h0000, 3'd0, 1'b1, 1'b0}},
    '{1'b1, '{MODE_START, 8'h80, 16'h8000, 8'd1,   8'h80},  '{1'b1, 16'h8000, 3'd7, 1'b0, 1'b0}},
    '{1'b1, '{MODE_TICK,  8'h00, 16'h0000, 8'd0,   8'd0},   NO_GRANT},
    '{1'b1, '{MODE_TICK,  8'h00, 16'h0000, 8'd0,   8'd0},   NO_GRANT},
    '{1'b1, '{MODE_TICK,  8'h00, 16'h0000, 8'd0,   8'd0},   '{1'b0, 16'h0000, 3'd0, 1'b0, 1'b1}},
    '{1'b1, '{MODE_TICK,  8'h00, 16'h0000, 8'd0,   8'd0},   NO_GRANT},
    '{1'b1, '{MODE_START, 8'h01, 16'h0001, 8'hFF,  8'hFF},  '{1'b1, 16'h0001, 3'd0, 1'b1, 1'b0}},
    '{1'b1, '{MODE_START, 8'h01, 16'h7FFF, 8'd1,   8'hFE},  NO_GRANT},
    '{1'b1, '{MODE_START, 8'hFF, 16'h00FF, 8'd0,   8'd0},   '{1'b1, 16'h00FF, 3'd1, 1'b0, 1'b0}},
    '{1'b1, '{MODE_START, 8'h02, 16'hF0F0, 8'hFF,  8'hFF},  '{1'b1, 16'hF0F0, 3'd1, 1'b0, 1'b0}},
    '{1'b1, '{MODE_START, 8'h03, 16'h0F0F, 8'd0,   8'hFE},  NO_GRANT},
    '{1'b1, '{MODE_START, 8'h03, 16'h1111, 8'd0,   8'hFF},  '{1'b1, 16'h1111, 3'd0, 1'b0, 1'b0}},
    '{1'b1, '{MODE_START, 8'hFE, 16'h2222, 8'd2,   8'h10},  '{1'b1, 16'h2222, 3'd2, 1'b0, 1'b0}},
    '{1'b0, '{MODE_START, 8'h04, 16'h3333, 8'd4,   8'h20},  NO_GRANT},
    '{1'b0, '{MODE_TICK,  8'h55, 16'hAAAA, 8'h80,  8'h01},  NO_GRANT},
    '{1'b0, '{MODE_START, 8'h40, 16'h4444, 8'd0,   8'd0},   NO_GRANT},
    '{1'b0, '{MODE_TICK,  8'hAA, 16'h5555, 8'h7F,  8'h80},  NO_GRANT},
    '{1'b0, '{MODE_START, 8'hFF, 16'h5A5A, 8'h80,  8'h7F},  NO_GRANT},
    '{1'b0, '{MODE_TICK,  8'h00, 16'h0000, 8'd0,   8'd0},   NO_GRANT}
  };

  function automatic alloc_res_t predict_alloc(input alloc_req_t req);
    alloc_res_t res;
    logic       found;
    res   = '0;
    found = 1'b0;
    if (req.mode == MODE_TICK) begin
      for (int ch = 0; ch < NUM_CHANNELS && ch < 8; ch++) begin
        if (ch_timer[ch] != 8'd0) begin
          ch_timer[ch] = ch_timer[ch] - 8'd1;
          if (ch_timer[ch] == 8'd0) begin
            ch_prio[ch] = 8'd0;
            if (ch == MUSIC_CHANNEL_INDEX) begin
              music_held = 1'b0;
              res.resume = 1'b1;
            end
          end
        end
      end
    end else begin
      for (int ch = 0; ch < NUM_CHANNELS && ch < 8; ch++) begin
        if (!found && req.mask[ch] &&
            (ch_timer[ch] == 8'd0 || req.prio >= ch_prio[ch])) begin
          found = 1'b1;
          // An untimed grant leaves the table and the music alone.
          if (req.dur != 8'd0) begin
            ch_timer[ch] = req.dur;
            ch_prio[ch]  = req.prio;
            if (ch == MUSIC_CHANNEL_INDEX) begin
              music_held = 1'b1;
              res.stop   = 1'b1;
            end
          end
          res.wv   = 1'b1;
          res.code = req.code & CODE_KEEP;
          res.ch   = 3'(ch);
        end
      end
    end
    return res;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic alloc_req_t random_request();
    alloc_req_t req;
    int         r;
    req.mode = ($urandom_range(0, 99) < 30) ? MODE_TICK : MODE_START;
    req.code = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 9);
    if (r < 4) req.mask = 8'(1 << $urandom_range(0, 7));
    else if (r < 8) req.mask = 8'($urandom_range(0, 255));
    else if (r < 9) req.mask = 8'hFF;
    else req.mask = 8'($urandom_range(0, 15));
    r = $urandom_range(0, 19);
    if (r < 5) req.dur = 8'd0;
    else if (r < 17) req.dur = 8'($urandom_range(1, 6));
    else req.dur = 8'($urandom_range(0, 255));
    // Small priorities make ties and preemption common.
    r = $urandom_range(0, 19);
    if (r < 12) req.prio = 8'($urandom_range(0, 3));
    else if (r < 17) req.prio = 8'($urandom_range(0, 255));
    else req.prio = (r == 17) ? 8'h00 : 8'hFF;
    return req;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (err_count < PRINT_CAP)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
               $time, what, got, exp_val, results_seen);
    err_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input int gap, input alloc_req_t req, input logic typed,
                           input alloc_res_t typed_res);
    alloc_res_t pred;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode         = req.mode;
    channel_mask = req.mask;
    sound_code   = req.code;
    duration     = req.dur;
    priority_req = req.prio;
    in_valid     = 1'b1;
    do @(posedge clk); while (in_stall);
    pred = predict_alloc(req);
    if (typed) pred = typed_res;
    predicted_allocs.push_back(pred);
    if (req.mode == MODE_TICK) n_ticks++;
    else if (pred.wv) n_grants++;
    else n_refused++;
    if (pred.stop) n_stops++;
    if (pred.resume) n_resumes++;
    @(negedge clk);
  endtask

  initial begin
    int gap;
    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = MODE_START;
    channel_mask = 8'h00;
    sound_code   = 16'h0000;
    duration     = 8'h00;
    priority_req = 8'h00;
    for (int ch = 0; ch < 8; ch++) begin
      ch_timer[ch] = 8'd0;
      ch_prio[ch]  = 8'd0;
    end
    music_held = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(idle_len(), directed_rows[i].req, directed_rows[i].typed,
                directed_rows[i].res);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      // Once in the middle the sender waits for the block to drain completely.
      if (i == RAND_ITEMS / 2) begin
        in_valid = 1'b0;
        while (predicted_allocs.size() != 0) @(negedge clk);
      end
      gap = ((i / 150) % 4 == 2) ? 0 : idle_len();
      send_item(gap, random_request(), 1'b0, NO_GRANT);
    end
    in_valid = 1'b0;

    while (predicted_allocs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d transactions: %0d ticks, %0d grants, %0d refused requests.",
             n_ticks + n_grants + n_refused, n_ticks, n_grants, n_refused);
    $display("Music stopped %0d times and resumed %0d times, held at the end: %0b; %0d mismatches.",
             n_stops, n_resumes, music_held, err_count);
    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Result side stalls; one long hold-off lets the block back up into its input.
  initial begin
    int stall_left;
    int free_left;
    stall_left = 0;
    free_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen >= HOLD_AT) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold_done = 1'b1;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (free_left > 0) begin
        out_stall = 1'b0;
        free_left--;
      end else begin
        out_stall  = 1'b0;
        free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(0, 8);
        stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (predicted_allocs.size() == 0) begin
        report_mismatch("result with nothing outstanding", 1, 0);
      end else begin
        want = predicted_allocs.pop_front();
        if (write_valid != want.wv)
          report_mismatch("write_valid", write_valid, want.wv);
        if (code_out != want.code)
          report_mismatch("code_out", code_out, want.code);
        if (granted_channel != want.ch)
          report_mismatch("granted_channel", granted_channel, want.ch);
        if (music_stop != want.stop)
          report_mismatch("music_stop", music_stop, want.stop);
        if (music_resume != want.resume)
          report_mismatch("music_resume", music_resume, want.resume);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, predicted_allocs.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
sv/sca_pkg.sv
sv/sca_table.sv
sv/sca_alu.sv
sv/sound_channel_priority_allocator.sv
dv/tb_top.sv
